>>> design/thop_pkg.sv
// Package for the TCP header and option parser.
// Holds constants, the option walk phase type and the result record type.
package thop_pkg;

    localparam int DefMaxSackBlocks = 4;
    localparam int FixedLen         = 20;
    localparam int SackBlockBytes   = 8;
    localparam int OptHdrBytes      = 2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_OFF   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [7:0] OPT_EOL      = 8'd0;
    localparam logic [7:0] OPT_NOP      = 8'd1;
    localparam logic [7:0] OPT_MSS      = 8'd2;
    localparam logic [7:0] OPT_WSCALE   = 8'd3;
    localparam logic [7:0] OPT_SACKPERM = 8'd4;
    localparam logic [7:0] OPT_SACK     = 8'd5;

    localparam logic REC_SACK    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef struct packed {
        logic        record_kind;
        logic [1:0]  status;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [15:0] window_size;
        logic [15:0] header_checksum;
        logic [15:0] urgent_pointer;
        logic [5:0]  header_length;
        logic [15:0] mss_value;
        logic [11:0] option_summary;
    } t_record;

endpackage

>>> design/thop_if.sv
// Channel interfaces for the TCP header and option parser.
// The record fields are declared one by one; nothing from thop_pkg is used.
interface thop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;
    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface thop_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [1:0]  status;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [15:0] window_size;
    logic [15:0] header_checksum;
    logic [15:0] urgent_pointer;
    logic [5:0]  header_length;
    logic [15:0] mss_value;
    logic [11:0] option_summary;
    modport source (output valid, output record_kind, output status, output source_port,
                    output destination_port, output word_a, output word_b,
                    output window_size, output header_checksum, output urgent_pointer,
                    output header_length, output mss_value, output option_summary,
                    input ready);
    modport sink   (input valid, input record_kind, input status, input source_port,
                    input destination_port, input word_a, input word_b,
                    input window_size, input header_checksum, input urgent_pointer,
                    input header_length, input mss_value, input option_summary,
                    output ready);
endinterface

>>> design/thop_core.sv
// Per-byte parse state and record generation for the TCP header parser.
// Depends on thop_pkg; produces up to two records for each accepted byte.
module thop_core #(
    parameter int MAX_SACK_BLOCKS = thop_pkg::DefMaxSackBlocks
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_sack_valid,
    output thop_pkg::t_record o_sack_rec,
    output logic              o_sum_valid,
    output thop_pkg::t_record o_sum_rec
);
    import thop_pkg::*;

    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_off, n_off;
    logic [31:0] r_ports, n_ports;
    logic [63:0] r_seqack, n_seqack;
    logic [47:0] r_wcu, n_wcu;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [5:0]  r_left, n_left;
    logic [5:0]  r_tot, n_tot;
    logic [15:0] r_mss, n_mss;
    logic [7:0]  r_ws, n_ws;
    logic [3:0]  r_flags, n_flags;
    logic [63:0] r_sack, n_sack;
    logic [2:0]  r_nsack, n_nsack;
    logic        r_fin, n_fin;

    logic [5:0]  rem;
    logic [5:0]  kidx;
    logic [1:0]  sum_status;
    logic        in_opt;

    always_comb begin
        n_pos = r_pos; n_off = r_off; n_ports = r_ports; n_seqack = r_seqack;
        n_wcu = r_wcu; n_phase = r_phase; n_kind = r_kind; n_left = r_left;
        n_tot = r_tot; n_mss = r_mss; n_ws = r_ws; n_flags = r_flags;
        n_sack = r_sack; n_nsack = r_nsack; n_fin = r_fin;
        o_sack_valid = 1'b0;
        o_sum_valid  = 1'b0;
        sum_status   = ST_OK;
        rem    = r_off - r_pos;
        kidx   = (r_tot - 6'(OptHdrBytes)) - r_left;
        in_opt = (r_pos >= 6'(FixedLen)) && (r_pos < r_off);
        if (!r_fin) begin
            if (r_pos < 6'd4) begin
                n_ports = {r_ports[23:0], i_byte};
            end else if (r_pos < 6'd12) begin
                n_seqack = {r_seqack[55:0], i_byte};
            end else if (r_pos == 6'd12) begin
                n_off = {i_byte[7:4], 2'b00};
            end else if (r_pos >= 6'd14 && r_pos < 6'(FixedLen)) begin
                n_wcu = {r_wcu[39:0], i_byte};
            end else if (in_opt) begin
                case (r_phase)
                    PH_KIND: begin
                        if (i_byte == OPT_EOL) begin
                            n_phase = PH_STOP;
                        end else if (i_byte == OPT_NOP) begin
                            n_phase = PH_KIND;
                        end else if (rem <= 6'd2) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_kind  = i_byte;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (i_byte < 8'(OptHdrBytes) || i_byte > ({2'b00, rem} + 8'd1)) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_tot = i_byte[5:0];
                            if (r_kind == OPT_SACK && i_byte > 8'(OptHdrBytes))
                                n_flags[3] = 1'b1;
                            if (r_kind == OPT_SACKPERM && i_byte == 8'd2)
                                n_flags[2] = 1'b1;
                            n_sack = '0;
                            if (i_byte == 8'(OptHdrBytes)) begin
                                n_phase = PH_KIND;
                            end else begin
                                n_left  = i_byte[5:0] - 6'(OptHdrBytes);
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_sack = {r_sack[55:0], i_byte};
                        if (r_kind == OPT_SACK && kidx[2:0] == 3'(SackBlockBytes - 1)
                            && r_nsack < 3'(MAX_SACK_BLOCKS)) begin
                            o_sack_valid = 1'b1;
                            n_nsack = r_nsack + 3'd1;
                        end
                        n_left = r_left - 6'd1;
                        if (n_left == 6'd0) begin
                            if (r_kind == OPT_MSS && r_tot == 6'd4) begin
                                n_mss = n_sack[15:0];
                                n_flags[0] = 1'b1;
                            end else if (r_kind == OPT_WSCALE && r_tot == 6'd3) begin
                                n_ws = n_sack[7:0];
                                n_flags[1] = 1'b1;
                            end
                            n_phase = PH_KIND;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
            n_pos = r_pos + 6'd1;
            if (r_pos < 6'(FixedLen - 1)) begin
                if (i_last) begin
                    o_sum_valid = 1'b1; sum_status = ST_SHORT; n_fin = 1'b1;
                end
            end else if (r_pos == 6'(FixedLen - 1) && n_off < 6'(FixedLen)) begin
                o_sum_valid = 1'b1; sum_status = ST_BAD_OFF; n_fin = 1'b1;
            end else if ({1'b0, r_pos} + 7'd1 >= {1'b0, n_off}) begin
                o_sum_valid = 1'b1; sum_status = ST_OK; n_fin = 1'b1;
            end else if (i_last) begin
                o_sum_valid = 1'b1; sum_status = ST_TRUNCATED; n_fin = 1'b1;
            end
        end

        o_sack_rec             = '0;
        o_sack_rec.record_kind = REC_SACK;
        o_sack_rec.word_a      = n_sack[63:32];
        o_sack_rec.word_b      = n_sack[31:0];

        o_sum_rec             = '0;
        o_sum_rec.record_kind = REC_SUMMARY;
        o_sum_rec.status      = sum_status;
        if (sum_status != ST_SHORT) begin
            o_sum_rec.source_port      = n_ports[31:16];
            o_sum_rec.destination_port = n_ports[15:0];
            o_sum_rec.word_a           = n_seqack[63:32];
            o_sum_rec.word_b           = n_seqack[31:0];
            o_sum_rec.window_size      = n_wcu[47:32];
            o_sum_rec.header_checksum  = n_wcu[31:16];
            o_sum_rec.urgent_pointer   = n_wcu[15:0];
            o_sum_rec.header_length    = n_off;
            if (sum_status == ST_OK) begin
                o_sum_rec.mss_value      = n_mss;
                o_sum_rec.option_summary = {n_ws, n_flags};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos <= '0; r_off <= '0; r_ports <= '0; r_seqack <= '0; r_wcu <= '0;
            r_phase <= PH_KIND; r_kind <= '0; r_left <= '0; r_tot <= '0;
            r_mss <= '0; r_ws <= '0; r_flags <= '0; r_sack <= '0;
            r_nsack <= '0; r_fin <= 1'b0;
        end else if (i_en) begin
            r_pos <= n_pos; r_off <= n_off; r_ports <= n_ports; r_seqack <= n_seqack;
            r_wcu <= n_wcu; r_phase <= n_phase; r_kind <= n_kind; r_left <= n_left;
            r_tot <= n_tot; r_mss <= n_mss; r_ws <= n_ws; r_flags <= n_flags;
            r_sack <= n_sack; r_nsack <= n_nsack; r_fin <= n_fin;
        end
    end
endmodule

>>> design/thop_out_buf.sv
// Two-entry result buffer for the TCP header parser.
// Depends on thop_pkg; holds the SACK and summary records of one byte.
module thop_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_a_valid,
    input  thop_pkg::t_record i_a,
    input  logic              i_b_valid,
    input  thop_pkg::t_record i_b,
    input  logic              i_ready,
    output logic              o_empty_next,
    output logic              o_valid,
    output thop_pkg::t_record o_rec
);
    import thop_pkg::*;

    logic    r_v0, r_v1;
    t_record r_e0, r_e1;
    logic    pop;

    assign pop          = r_v0 && i_ready;
    assign o_valid      = r_v0;
    assign o_rec        = r_e0;
    assign o_empty_next = !r_v1 && (!r_v0 || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_load) begin
            r_v0 <= i_a_valid || i_b_valid;
            r_v1 <= i_a_valid && i_b_valid;
        end else if (pop) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_e0 <= i_a_valid ? i_a : i_b;
            r_e1 <= i_b;
        end else if (pop) begin
            r_e0 <= r_e1;
        end
    end
endmodule

>>> design/tcp_header_option_parser_unit.sv
// TCP header and option parser: one segment byte per cycle in, header summary
// and SACK block records out. A byte is accepted in every cycle while the result
// buffer drains; a byte that yields a SACK record and the summary fills both
// entries, so ready drops until one is sent. Depends on thop_pkg, thop_if.
module tcp_header_option_parser_unit #(
    parameter int MAX_SACK_BLOCKS = thop_pkg::DefMaxSackBlocks
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thop_in_if.sink    i_in,
    thop_out_if.source o_out
);
    import thop_pkg::*;

    logic    accept, sack_v, sum_v, empty_next;
    t_record sack_rec, sum_rec, rec;

    assign i_in.ready = empty_next;
    assign accept     = i_in.valid && empty_next;

    thop_core #(.MAX_SACK_BLOCKS(MAX_SACK_BLOCKS)) u_core (
        .i_clk, .i_rst_n, .i_en(accept), .i_byte(i_in.data_byte),
        .i_last(i_in.end_of_buffer), .o_sack_valid(sack_v), .o_sack_rec(sack_rec),
        .o_sum_valid(sum_v), .o_sum_rec(sum_rec)
    );

    thop_out_buf u_buf (
        .i_clk, .i_rst_n, .i_load(accept), .i_a_valid(sack_v), .i_a(sack_rec),
        .i_b_valid(sum_v), .i_b(sum_rec), .i_ready(o_out.ready),
        .o_empty_next(empty_next), .o_valid(o_out.valid), .o_rec(rec)
    );

    assign o_out.record_kind      = rec.record_kind;
    assign o_out.status           = rec.status;
    assign o_out.source_port      = rec.source_port;
    assign o_out.destination_port = rec.destination_port;
    assign o_out.word_a           = rec.word_a;
    assign o_out.word_b           = rec.word_b;
    assign o_out.window_size      = rec.window_size;
    assign o_out.header_checksum  = rec.header_checksum;
    assign o_out.urgent_pointer   = rec.urgent_pointer;
    assign o_out.header_length    = rec.header_length;
    assign o_out.mss_value        = rec.mss_value;
    assign o_out.option_summary   = rec.option_summary;
endmodule
